### rtl/plid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and codes for the positional list insert/delete unit.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_DUMP   = 2'd3
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SOP_HOLD   = 2'd0,
        SOP_INSERT = 2'd1,
        SOP_DELETE = 2'd2,
        SOP_ROTATE = 2'd3
    } t_store_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    // Control part of one result beat; the value joins it from the store head.
    typedef struct packed {
        t_status                status;
        logic [IDX_OUT_W-1:0]   index;
        logic [CNT_OUT_W-1:0]   entry_count;
        logic                   last;
        logic                   show_value;
    } t_beat_ctl;

endpackage : plid_pkg
`default_nettype wire

### rtl/plid_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plid_store
// Register file of list entries with parallel shift up, shift down and rotate.
// ----------------------------------------------------------------------------
module plid_store #(
    parameter int DEPTH = 64,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire plid_pkg::t_store_op      i_op,
    input  wire logic [IW-1:0]            i_pos,
    input  wire logic [plid_pkg::VAL_W-1:0] i_elem,
    output logic [plid_pkg::VAL_W-1:0]    o_head
);
    import plid_pkg::*;

    logic [VAL_W-1:0] r_entries [DEPTH];
    logic [VAL_W-1:0] n_entries [DEPTH];

    // Insert: write at pos, shift up above it. Delete: shift down from pos.
    // Rotate: move entries 1..pos down one, entry 0 wraps to pos.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            case (i_op)
                SOP_INSERT: begin
                    if (i == int'(i_pos)) begin
                        n_entries[i] = i_elem;
                    end else if (i > 0 && i > int'(i_pos)) begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
                SOP_DELETE: begin
                    if (i >= int'(i_pos) && i < DEPTH - 1) begin
                        n_entries[i] = r_entries[i+1];
                    end
                end
                SOP_ROTATE: begin
                    if (i == int'(i_pos)) begin
                        n_entries[i] = r_entries[0];
                    end else if (i < int'(i_pos) && i < DEPTH - 1) begin
                        n_entries[i] = r_entries[i+1];
                    end
                end
                default: begin
                    n_entries[i] = r_entries[i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_entries[i] <= n_entries[i];
        end
    end

    assign o_head = r_entries[0];

endmodule : plid_store
`default_nettype wire

### rtl/plid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plid_ctrl
// Request decode, status checks, entry count and dump sequencer.
// ----------------------------------------------------------------------------
module plid_ctrl #(
    parameter int DEPTH = 64,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    input  wire plid_pkg::t_mode            i_req_mode,
    input  wire logic [plid_pkg::POS_W-1:0] i_req_pos,
    input  wire logic                       i_out_free,
    output logic                            o_consume,
    output logic                            o_beat_load,
    output plid_pkg::t_beat_ctl             o_beat,
    output plid_pkg::t_store_op             o_store_op,
    output logic [IW-1:0]                   o_store_pos
);
    import plid_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx,   n_idx;

    logic [CMPW-1:0] pos_ext, cnt_ext;
    logic            full, empty, dump_go, dump_last;
    logic [IW-1:0]   top_idx;

    assign pos_ext   = CMPW'(i_req_pos);
    assign cnt_ext   = CMPW'(r_count);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign top_idx   = IW'(r_count - 1'b1);
    assign o_consume = i_req_valid && (r_state == S_IDLE) && i_out_free;
    assign dump_go   = o_consume && (i_req_mode == MODE_DUMP) && !empty;
    assign dump_last = (r_idx == top_idx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (dump_go && (r_count != CW'(1))) n_state = S_DUMP;
            end
            S_DUMP: begin
                if (i_out_free && dump_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_beat_load            = 1'b0;
        o_store_op             = SOP_HOLD;
        o_store_pos            = IW'(i_req_pos);
        n_count                = r_count;
        n_idx                  = r_idx;
        o_beat.status          = ST_OK;
        o_beat.index           = '0;
        o_beat.last            = 1'b1;
        o_beat.show_value      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_consume) begin
                    o_beat_load = 1'b1;
                    case (i_req_mode)
                        MODE_APPEND: begin
                            if (full) begin
                                o_beat.status = ST_FULL;
                            end else begin
                                o_store_op  = SOP_INSERT;
                                o_store_pos = IW'(r_count);
                                n_count     = r_count + 1'b1;
                            end
                        end
                        MODE_INSERT: begin
                            if (full) begin
                                o_beat.status = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                o_beat.status = ST_RANGE;
                            end else begin
                                o_store_op = SOP_INSERT;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        MODE_DELETE: begin
                            if (empty) begin
                                o_beat.status = ST_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                o_beat.status = ST_RANGE;
                            end else begin
                                o_store_op = SOP_DELETE;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        MODE_DUMP: begin
                            if (empty) begin
                                o_beat.status = ST_EMPTY;
                            end else begin
                                o_store_op        = SOP_ROTATE;
                                o_store_pos       = top_idx;
                                o_beat.last       = (r_count == CW'(1));
                                o_beat.show_value = 1'b1;
                                n_idx             = IW'(1);
                            end
                        end
                        default: o_beat.status = ST_OK;
                    endcase
                end
            end
            S_DUMP: begin
                if (i_out_free) begin
                    o_beat_load       = 1'b1;
                    o_store_op        = SOP_ROTATE;
                    o_store_pos       = top_idx;
                    o_beat.index      = IDX_OUT_W'(r_idx);
                    o_beat.last       = dump_last;
                    o_beat.show_value = 1'b1;
                    n_idx             = r_idx + 1'b1;
                end
            end
            default: o_store_op = SOP_HOLD;
        endcase
        o_beat.entry_count = CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

endmodule : plid_ctrl
`default_nettype wire

### rtl/positional_list_insert_delete_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete_unit
// Bounded ordered list of signed words with append, insert, delete and dump.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  --------------------------------------------
//  request  i_in_valid/o_in_ready  i_mode, i_position, i_element
//  result   o_out_valid/i_out_ready o_status, o_item_index, o_item_value,
//                                  o_entry_count, o_last
//
//  Append, insert, delete and refused requests each give one beat; a dump
//  of N entries gives N beats, one per cycle while the result is not
//  stalled, paced by the list head register rotating round the stored entries.
//  A request passes the input register and then the result register before
//  its first result beat. Reset clears the count and the sequencer;
//  the entries themselves are not cleared. A stalled result holds the result
//  register and the sequencer; the input register still takes one request.
//
module positional_list_insert_delete_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [plid_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [plid_pkg::VAL_W-1:0] i_element,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [plid_pkg::ST_W-1:0]           o_status,
    output logic [plid_pkg::IDX_OUT_W-1:0]      o_item_index,
    output logic signed [plid_pkg::VAL_W-1:0]   o_item_value,
    output logic [plid_pkg::CNT_OUT_W-1:0]      o_entry_count,
    output logic                                o_last
);
    import plid_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Input register
    logic             r_in_valid;
    t_mode            r_in_mode;
    logic [POS_W-1:0] r_in_pos;
    logic [VAL_W-1:0] r_in_elem;

    // Result register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [IDX_OUT_W-1:0] r_out_index;
    logic [VAL_W-1:0]     r_out_value;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic                 r_out_last;

    logic          out_free, consume, beat_load;
    t_beat_ctl     beat;
    t_store_op     store_op;
    logic [IW-1:0] store_pos;
    logic [VAL_W-1:0] head;

    // The result slot frees when empty or when its beat leaves this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || consume;

    plid_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_in_valid),
        .i_req_mode  (r_in_mode),
        .i_req_pos   (r_in_pos),
        .i_out_free  (out_free),
        .o_consume   (consume),
        .o_beat_load (beat_load),
        .o_beat      (beat),
        .o_store_op  (store_op),
        .o_store_pos (store_pos)
    );

    plid_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk  (i_clk),
        .i_op   (store_op),
        .i_pos  (store_pos),
        .i_elem (r_in_elem),
        .o_head (head)
    );

    // Hold a request until the controller takes it; take a new one behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_mode <= t_mode'(i_mode);
            r_in_pos  <= i_position;
            r_in_elem <= i_element;
        end
    end

    // Advance the result register on each beat the controller issues.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= beat_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_load) begin
            r_out_status <= beat.status;
            r_out_index  <= beat.index;
            r_out_value  <= beat.show_value ? head : '0;
            r_out_count  <= beat.entry_count;
            r_out_last   <= beat.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_item_index  = r_out_index;
    assign o_item_value  = r_out_value;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

endmodule : positional_list_insert_delete_unit
`default_nettype wire

### sim/tb_positional_list_insert_delete_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete_unit
// Self-checking bench for the positional list: a directed table walks the
// empty and out-of-range cases, then random fill-to-full, drain and mixed
// episodes run under random sender gaps and receiver stalls. Every result
// beat is checked against its pinned row or a behavioural list in the bench.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete_unit;

    import plid_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int RANDOM_ITEMS   = 300;
    localparam int DRAIN_CYCLES   = 16;
    // No beat moves for this long: the block has hung. Longest legal quiet
    // stretch is a long sender gap overlapping a long receiver stall.
    localparam int WATCHDOG_LIMIT = 2000;

    // One expected result beat
    typedef struct packed {
        t_status                status;
        logic [IDX_OUT_W-1:0]   index;
        logic signed [VAL_W-1:0] value;
        logic [CNT_OUT_W-1:0]   count;
        logic                   last;
    } t_list_beat;

    // One row of the directed table; pinned rows carry the status and count
    // that can be read straight off the list, the rest go to the list model
    typedef struct packed {
        t_mode                  mode;
        logic [POS_W-1:0]       pos;
        logic signed [VAL_W-1:0] elem;
        logic                   pinned;
        t_status                status;
        logic [CNT_OUT_W-1:0]   count;
    } t_plan_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_mode;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_element;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [ST_W-1:0]         o_status;
    logic [IDX_OUT_W-1:0]    o_item_index;
    logic signed [VAL_W-1:0] o_item_value;
    logic [CNT_OUT_W-1:0]    o_entry_count;
    logic                    o_last;

    // Behavioural copy of the list and the beats still owed by the block
    logic signed [VAL_W-1:0] list_words [LIST_DEPTH];
    int                      list_len;
    t_list_beat              beats_due [$];

    int  mismatches;
    int  requests_sent;
    int  quiet_cycles;
    bit  stalls_on;
    int  stall_left;
    t_plan_row plan [25];

    positional_list_insert_delete_unit #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_element    (i_element),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_item_index (o_item_index),
        .o_item_value (o_item_value),
        .o_entry_count(o_entry_count),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // List model: apply one accepted request, queue the beats it owes
    // ------------------------------------------------------------------------
    function automatic void apply_request(input t_mode mode, input logic [POS_W-1:0] pos,
                                          input logic signed [VAL_W-1:0] elem,
                                          input bit emit);
        t_list_beat b;
        int         i;
        b.status = ST_OK;
        b.index  = '0;
        b.value  = '0;
        b.last   = 1'b1;
        if (mode == MODE_DUMP && list_len > 0) begin
            // A dump walks the list front to back, last beat on the tail
            for (i = 0; i < list_len; i++) begin
                b.index = i[IDX_OUT_W-1:0];
                b.value = list_words[i];
                b.count = list_len[CNT_OUT_W-1:0];
                b.last  = (i == list_len - 1);
                if (emit) beats_due.push_back(b);
            end
        end else begin
            case (mode)
                MODE_APPEND: begin
                    if (list_len >= LIST_DEPTH) begin
                        b.status = ST_FULL;
                    end else begin
                        list_words[list_len] = elem;
                        list_len++;
                    end
                end
                MODE_INSERT: begin
                    // Fullness wins over a bad position
                    if (list_len >= LIST_DEPTH) begin
                        b.status = ST_FULL;
                    end else if (pos > list_len) begin
                        b.status = ST_RANGE;
                    end else begin
                        for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                        list_words[pos] = elem;
                        list_len++;
                    end
                end
                MODE_DELETE: begin
                    // Emptiness wins over a bad position
                    if (list_len == 0) begin
                        b.status = ST_EMPTY;
                    end else if (pos >= list_len) begin
                        b.status = ST_RANGE;
                    end else begin
                        for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
                default: begin
                    b.status = ST_EMPTY;
                end
            endcase
            b.count = list_len[CNT_OUT_W-1:0];
            if (emit) beats_due.push_back(b);
        end
    endfunction

    function automatic t_plan_row plan_row(input t_mode mode, input int pos,
                                           input logic signed [VAL_W-1:0] elem,
                                           input bit pinned, input t_status status,
                                           input int count);
        t_plan_row r;
        r.mode   = mode;
        r.pos    = pos[POS_W-1:0];
        r.elem   = elem;
        r.pinned = pinned;
        r.status = status;
        r.count  = count[CNT_OUT_W-1:0];
        return r;
    endfunction

    // Gap length: mostly none, sometimes short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Element: random, with the extremes and all-zero/all-one mixed in
    function automatic logic signed [VAL_W-1:0] any_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: present at the falling edge, hold until the beat is
    // taken, then update the list model
    // ------------------------------------------------------------------------
    task automatic send_request(input t_mode mode, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] elem,
                                input bit pinned, input t_status status,
                                input logic [CNT_OUT_W-1:0] count);
        t_list_beat b;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_mode     = mode;
        i_position = pos;
        i_element  = elem;
        do @(posedge i_clk); while (!o_in_ready);
        if (pinned) begin
            b.status = status;
            b.index  = '0;
            b.value  = '0;
            b.count  = count;
            b.last   = 1'b1;
            beats_due.push_back(b);
            apply_request(mode, pos, elem, 1'b0);
        end else begin
            apply_request(mode, pos, elem, 1'b1);
        end
        requests_sent++;
    endtask

    task automatic send_random(input t_mode mode, input logic [POS_W-1:0] pos);
        send_request(mode, pos, any_word(), 1'b0, ST_OK, '0);
    endtask

    // Drop valid for a random gap; zero leaves valid high for back-to-back beats
    task automatic sender_gap(input bit gaps_on);
        int n;
        n = gaps_on ? gap_len() : 0;
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Hold off the sender until every owed beat has come back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
    endtask

    // Position that hits the list most of the time, anywhere otherwise
    function automatic logic [POS_W-1:0] pick_pos(input t_mode mode);
        if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 63));
        if (mode == MODE_INSERT && list_len < LIST_DEPTH)
            return POS_W'($urandom_range(0, list_len));
        if (mode == MODE_DELETE && list_len > 0)
            return POS_W'($urandom_range(0, list_len - 1));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, switched off for whole episodes at times
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            i_out_ready = 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare every taken beat with the oldest owed beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_beat b;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beats_due.size() == 0) begin
                $error("result beat with none owed: status %0d index %0d value %0d",
                       o_status, o_item_index, o_item_value);
                mismatches++;
            end else begin
                b = beats_due.pop_front();
                if (o_status !== b.status) begin
                    $error("status: expected %0d, actual %0d", b.status, o_status);
                    mismatches++;
                end
                if (o_item_index !== b.index) begin
                    $error("item_index: expected %0d, actual %0d", b.index, o_item_index);
                    mismatches++;
                end
                if (o_item_value !== b.value) begin
                    $error("item_value: expected %0d, actual %0d", b.value, o_item_value);
                    mismatches++;
                end
                if (o_entry_count !== b.count) begin
                    $error("entry_count: expected %0d, actual %0d", b.count, o_entry_count);
                    mismatches++;
                end
                if (o_last !== b.last) begin
                    $error("last: expected %0d, actual %0d", b.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int    row;
        int    kind;
        int    n;
        bit    gaps_on;
        t_mode mode;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_APPEND;
        i_position    = '0;
        i_element     = '0;
        i_out_ready   = 1'b0;
        stalls_on     = 1'b0;
        stall_left    = 0;
        mismatches    = 0;
        requests_sent = 0;
        quiet_cycles  = 0;
        list_len      = 0;
        for (row = 0; row < LIST_DEPTH; row++) list_words[row] = '0;

        // Directed table: refusals on an empty list, edge positions,
        // insert at the tail, shifts both ways, dumps of various sizes
        plan[0]  = plan_row(MODE_DUMP,   0,  32'sd0,          1, ST_EMPTY, 0);
        plan[1]  = plan_row(MODE_DELETE, 0,  32'sd0,          1, ST_EMPTY, 0);
        plan[2]  = plan_row(MODE_DELETE, 63, 32'sd0,          1, ST_EMPTY, 0);
        plan[3]  = plan_row(MODE_INSERT, 1,  32'sd5,          1, ST_RANGE, 0);
        plan[4]  = plan_row(MODE_INSERT, 63, -32'sd1,         1, ST_RANGE, 0);
        plan[5]  = plan_row(MODE_INSERT, 0,  32'sh7FFF_FFFF,  1, ST_OK,    1);
        plan[6]  = plan_row(MODE_APPEND, 63, 32'sh8000_0000,  1, ST_OK,    2);
        plan[7]  = plan_row(MODE_APPEND, 0,  -32'sd1,         1, ST_OK,    3);
        plan[8]  = plan_row(MODE_INSERT, 3,  32'sd0,          1, ST_OK,    4);
        plan[9]  = plan_row(MODE_INSERT, 5,  32'sd1,          1, ST_RANGE, 4);
        plan[10] = plan_row(MODE_DELETE, 4,  32'sd0,          1, ST_RANGE, 4);
        plan[11] = plan_row(MODE_INSERT, 1,  32'sh5555_5555,  0, ST_OK,    0);
        plan[12] = plan_row(MODE_DUMP,   0,  32'sd0,          0, ST_OK,    0);
        plan[13] = plan_row(MODE_DELETE, 4,  32'sd0,          0, ST_OK,    0);
        plan[14] = plan_row(MODE_DELETE, 0,  32'sd0,          0, ST_OK,    0);
        plan[15] = plan_row(MODE_INSERT, 2,  32'shAAAA_AAAA,  0, ST_OK,    0);
        plan[16] = plan_row(MODE_DUMP,   42, 32'sd0,          0, ST_OK,    0);
        plan[17] = plan_row(MODE_DELETE, 1,  32'sd0,          0, ST_OK,    0);
        plan[18] = plan_row(MODE_DELETE, 2,  32'sd0,          0, ST_OK,    0);
        plan[19] = plan_row(MODE_DELETE, 0,  32'sd0,          0, ST_OK,    0);
        plan[20] = plan_row(MODE_DUMP,   0,  32'sd0,          0, ST_OK,    0);
        plan[21] = plan_row(MODE_DELETE, 0,  32'sd0,          0, ST_OK,    0);
        plan[22] = plan_row(MODE_DUMP,   0,  32'sd0,          1, ST_EMPTY, 0);
        plan[23] = plan_row(MODE_APPEND, 21, 32'sh1234_5678,  1, ST_OK,    1);
        plan[24] = plan_row(MODE_DELETE, 0,  32'sd0,          1, ST_OK,    0);

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        stalls_on = 1'b1;
        for (row = 0; row < 25; row++) begin
            send_request(plan[row].mode, plan[row].pos, plan[row].elem,
                         plan[row].pinned, plan[row].status, plan[row].count);
            sender_gap(1'b1);
        end
        settle();

        // Random episodes. The first one always fills the list to the brim.
        requests_sent = 0;
        kind = 0;
        while (requests_sent < RANDOM_ITEMS) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (kind < 2) begin
                // Fill to full by appends and inserts, then poke the full list
                while (list_len < LIST_DEPTH) begin
                    mode = ($urandom_range(0, 1) == 0) ? MODE_APPEND : MODE_INSERT;
                    send_random(mode, POS_W'($urandom_range(0, list_len)));
                    sender_gap(gaps_on);
                end
                send_random(MODE_APPEND, POS_W'($urandom_range(0, 63)));
                send_random(MODE_INSERT, POS_W'($urandom_range(0, 63)));
                send_random(MODE_DUMP, POS_W'($urandom_range(0, 63)));
                send_random(MODE_DELETE, POS_W'(63));
                send_random(MODE_INSERT, POS_W'(63));
                send_random(MODE_DELETE, POS_W'($urandom_range(0, 63)));
            end else if (kind < 4) begin
                // Drain to empty, then poke the empty list
                while (list_len > 0) begin
                    send_random(MODE_DELETE, pick_pos(MODE_DELETE));
                    sender_gap(gaps_on);
                end
                send_random(MODE_DELETE, POS_W'($urandom_range(0, 63)));
                send_random(MODE_DUMP, POS_W'($urandom_range(0, 63)));
                send_random(MODE_INSERT, POS_W'($urandom_range(1, 63)));
            end else begin
                // Mixed traffic, dumps kept rare
                n = $urandom_range(8, 20);
                repeat (n) begin
                    case ($urandom_range(0, 15))
                        0, 1, 2, 3, 4:    mode = MODE_APPEND;
                        5, 6, 7, 8, 9:    mode = MODE_INSERT;
                        10, 11, 12, 13:   mode = MODE_DELETE;
                        default:          mode = MODE_DUMP;
                    endcase
                    send_random(mode, pick_pos(mode));
                    sender_gap(gaps_on);
                end
            end
            if ($urandom_range(0, 4) == 0) settle();
            kind = (kind == 0) ? 4 : $urandom_range(0, 9);
        end

        // Drain: drop valid, wait for the owed beats, then a short tail
        // in which any stray extra beat would show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/plid_pkg.sv
rtl/plid_store.sv
rtl/plid_ctrl.sv
rtl/positional_list_insert_delete_unit.sv
sim/tb_positional_list_insert_delete_unit.sv
